// ===== rtl/core/grid_segment_collision_check_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Grid segment collision check: assertion macros
// Shared property forms for the checker of the collision check unit.
// ----------------------------------------------------------------------------
`ifndef GRID_SEGMENT_COLLISION_CHECK_UNIT_ASSERT_SVH
`define GRID_SEGMENT_COLLISION_CHECK_UNIT_ASSERT_SVH

// same-cycle implication
`define GSC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gsc: same-cycle property failed");

// next-cycle implication
`define GSC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gsc: next-cycle property failed");

`endif

// ===== rtl/core/gsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid segment collision check: package
// Field widths, operation and register codes, default map size.
// ----------------------------------------------------------------------------
package gsc_pkg;

  // coordinate and register widths
  localparam int COORD_W   = 8;
  localparam int CFG_W     = 9;
  localparam int REG_IDX_W = 1;
  localparam int CFG_MAX   = 511;

  // default map size
  localparam int GRID_W_DEF = 256;
  localparam int GRID_H_DEF = 256;

  // reset value of both size registers
  localparam logic [CFG_W-1:0] GRID_SIZE_RST = 9'd256;

  // item operations
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

endpackage

// ===== rtl/core/gsc_channels.sv =====
// ----------------------------------------------------------------------------
// Grid segment collision check: channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gsc_req_if;
  import gsc_pkg::*;
  logic               valid;
  logic               ready;
  logic               op;
  logic [COORD_W-1:0] cell_col;
  logic [COORD_W-1:0] cell_row;
  logic               cell_blocked;
  logic [COORD_W-1:0] seg_start_x;
  logic [COORD_W-1:0] seg_start_y;
  logic [COORD_W-1:0] seg_end_x;
  logic [COORD_W-1:0] seg_end_y;

  modport source (
    output valid, op, cell_col, cell_row, cell_blocked,
    output seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    input  ready
  );
  modport sink (
    input  valid, op, cell_col, cell_row, cell_blocked,
    input  seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    output ready
  );
endinterface

interface gsc_rsp_if;
  logic valid;
  logic ready;
  logic path_blocked;

  modport source (output valid, path_blocked, input ready);
  modport sink (input valid, path_blocked, output ready);
endinterface

interface gsc_cfg_if;
  import gsc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// ===== rtl/core/grid_segment_collision_check_unit.sv =====
// ----------------------------------------------------------------------------
// Grid segment collision check unit
// Checks a straight segment against a one-bit occupancy map held on chip.
//
// Channels: req carries items; op selects a map cell write or a segment
// check. rsp returns one path_blocked item per check, none per write. cfg
// writes grid_width (index 0) and grid_height (index 1) and is always ready;
// the user must write it only while the block is idle (not enforced here).
// Sequencing: a write is taken and the block stays ready. A check holds
// req.ready low through a setup state, a step per point through the shared
// step unit along the longer axis (at most 255 points), the last map read
// and the load of the result; a blocked point found early ends the steps, and
// equal endpoints skip them.
// Reset clears the size registers to 256 and empties the result register;
// map contents stay undefined until written.
// A stalled rsp holds its item; the block still takes writes, and a finished
// check waits in place until the result register is free.
// ----------------------------------------------------------------------------
module grid_segment_collision_check_unit #(
  parameter int GRID_W = gsc_pkg::GRID_W_DEF,
  parameter int GRID_H = gsc_pkg::GRID_H_DEF
) (
  input  logic clk,
  input  logic rst,
  gsc_req_if.sink   req,
  gsc_rsp_if.source rsp,
  gsc_cfg_if.sink   cfg
);
  import gsc_pkg::*;

  localparam int DEPTH = GRID_W * GRID_H;
  localparam int AW    = $clog2(DEPTH);
  localparam int WCAP  = (GRID_W > CFG_MAX) ? CFG_MAX : GRID_W;
  localparam int HCAP  = (GRID_H > CFG_MAX) ? CFG_MAX : GRID_H;
  localparam logic [CFG_W-1:0] W_CAP = CFG_W'(WCAP);
  localparam logic [CFG_W-1:0] H_CAP = CFG_W'(HCAP);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SETUP  = 2'd1;
  localparam logic [1:0] ST_STEP   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]         state;
  logic [CFG_W-1:0]   grid_width;
  logic [CFG_W-1:0]   grid_height;
  logic [COORD_W-1:0] sx, sy, ex, ey;
  logic [COORD_W-1:0] k, k_hi, q, ad;
  logic signed [9:0]  r;
  logic signed [8:0]  sd;
  logic               x_major, issuing;
  logic               p_vld, p_out, p_last;
  logic               rd_bit, blocked_res;
  logic               rsp_vld, rsp_blk;
  logic               occ [DEPTH];

  // setup terms
  logic signed [8:0]  dx, dy;
  logic [COORD_W-1:0] adx, ady;
  logic               x_major_c;

  // step unit terms
  logic [CFG_W-1:0]   w_eff, h_eff, row9;
  logic [COORD_W-1:0] px, py;
  logic               outside, hit, last_pt;
  logic signed [9:0]  r_sum, ad_s;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               wr_en, req_acc, rsp_load;

  // size registers clipped to the store
  assign w_eff = (grid_width > W_CAP) ? W_CAP : grid_width;
  assign h_eff = (grid_height > H_CAP) ? H_CAP : grid_height;

  // segment deltas and axis choice
  always_comb begin
    dx = $signed({1'b0, ex}) - $signed({1'b0, sx});
    dy = $signed({1'b0, ey}) - $signed({1'b0, sy});
    adx = dx[8] ? COORD_W'(-dx) : COORD_W'(dx);
    ady = dy[8] ? COORD_W'(-dy) : COORD_W'(dy);
    x_major_c = (dx != 9'sd0) && (ady <= adx);
  end

  // current point, map bounds and read address
  always_comb begin
    px      = x_major ? k : q;
    py      = x_major ? q : k;
    outside = ({1'b0, px} >= w_eff) || ({1'b0, py} >= h_eff);
    row9    = h_eff - CFG_W'(1) - {1'b0, py};
    rd_addr = outside ? '0 : AW'(row9[COORD_W-1:0]) * AW'(GRID_W) + AW'(px);
    last_pt = (k == k_hi - COORD_W'(1));
    ad_s    = $signed({2'b00, ad});
    r_sum   = r + 10'(sd);
    hit     = p_vld && (p_out || rd_bit);
  end

  // handshakes
  assign req_acc  = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_vld;
  assign rsp.path_blocked = rsp_blk;
  assign rsp_load = (state == ST_FINISH) && (!rsp_vld || rsp.ready);

  // map write port
  assign wr_en   = req_acc && (req.op == OP_WRITE) &&
                   (int'(req.cell_col) < GRID_W) && (int'(req.cell_row) < GRID_H);
  assign wr_addr = AW'(req.cell_row) * AW'(GRID_W) + AW'(req.cell_col);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      occ[wr_addr] <= req.cell_blocked;
    end
  end

  // map read port
  always_ff @(posedge clk) begin
    rd_bit <= occ[rd_addr];
  end

  // size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_SIZE_RST;
      grid_height <= GRID_SIZE_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_GRID_WIDTH:  grid_width  <= cfg.wdata;
        REG_GRID_HEIGHT: grid_height <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // capture segment endpoints
  always_ff @(posedge clk) begin
    if (req_acc && (req.op == OP_CHECK)) begin
      sx <= req.seg_start_x;
      sy <= req.seg_start_y;
      ex <= req.seg_end_x;
      ey <= req.seg_end_y;
    end
  end

  // sequencer and shared step unit
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      issuing <= 1'b0;
      p_vld   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_acc && (req.op == OP_CHECK)) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          // start at the lower end of the major axis, remainder zero
          x_major <= x_major_c;
          r       <= '0;
          p_vld   <= 1'b0;
          if (x_major_c) begin
            k    <= (sx < ex) ? sx : ex;
            k_hi <= (sx < ex) ? ex : sx;
            q    <= (sx < ex) ? sy : ey;
            ad   <= adx;
            sd   <= dx[8] ? -dy : dy;
          end else begin
            k    <= (sy < ey) ? sy : ey;
            k_hi <= (sy < ey) ? ey : sy;
            q    <= (sy < ey) ? sx : ex;
            ad   <= ady;
            sd   <= dy[8] ? -dx : dx;
          end
          if (x_major_c || (sy != ey)) begin
            issuing <= 1'b1;
            state   <= ST_STEP;
          end else begin
            blocked_res <= 1'b0;
            state       <= ST_FINISH;
          end
        end
        ST_STEP: begin
          if (hit) begin
            // blocked point found: drop the rest
            blocked_res <= 1'b1;
            issuing     <= 1'b0;
            p_vld       <= 1'b0;
            state       <= ST_FINISH;
          end else if (p_vld && p_last) begin
            blocked_res <= 1'b0;
            p_vld       <= 1'b0;
            state       <= ST_FINISH;
          end else if (issuing) begin
            // issue this point and advance along the line
            p_vld  <= 1'b1;
            p_out  <= outside;
            p_last <= last_pt;
            k      <= k + COORD_W'(1);
            if (r_sum >= ad_s) begin
              q <= q + COORD_W'(1);
              r <= r_sum - ad_s;
            end else if (r_sum < 10'sd0) begin
              q <= q - COORD_W'(1);
              r <= r_sum + ad_s;
            end else begin
              r <= r_sum;
            end
            if (last_pt) begin
              issuing <= 1'b0;
            end
          end else begin
            p_vld <= 1'b0;
          end
        end
        ST_FINISH: begin
          if (rsp_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld <= 1'b0;
    end else if (rsp_load) begin
      rsp_vld <= 1'b1;
    end else if (rsp.ready) begin
      rsp_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_blk <= blocked_res;
    end
  end

endmodule

// ===== rtl/core/gsc_checker.sv =====
// ----------------------------------------------------------------------------
// Grid segment collision check: port checker
// Watches the top-level ports for sequencing slips; bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_segment_collision_check_unit_assert.svh"

module gsc_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic req_op,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_path_blocked
);
  import gsc_pkg::*;

  // a new result only appears at the end of a busy check
  `GSC_ASSERT_IMP(a_rsp_after_busy, clk, rst, $rose(rsp_valid), $past(!req_ready))

  // an accepted check makes the block busy
  `GSC_ASSERT_NXT(a_check_busy, clk, rst, req_valid && req_ready && (req_op == OP_CHECK), !req_ready)

  // a map write keeps the block ready
  `GSC_ASSERT_NXT(a_write_ready, clk, rst, req_valid && req_ready && (req_op == OP_WRITE), req_ready)

  // a stalled result holds
  `GSC_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_path_blocked))

endmodule

bind grid_segment_collision_check_unit gsc_checker u_gsc_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .req_op           (req.op),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_path_blocked (rsp.path_blocked)
);
